// ----- rtl/tpt_pkg.sv -----
// Package for the two-level page table manager: beat types, operation and
// register codes, field constants and default sizes.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package tpt_pkg;

    // Default sizes of the directory and of each page table.
    localparam int DIR_ENTRIES_DEF   = 16;
    localparam int TABLE_ENTRIES_DEF = 1024;

    // Entry word layout: frame in bits 31..12, flags in bits 11..0.
    localparam logic [31:0] FRAME_MASK  = 32'hFFFF_F000;
    localparam int          PRESENT_BIT = 0;

    // Operation codes.
    localparam logic [2:0] OP_WR_DIR = 3'd0;
    localparam logic [2:0] OP_WR_TAB = 3'd1;
    localparam logic [2:0] OP_RD_DIR = 3'd2;
    localparam logic [2:0] OP_RD_TAB = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;
    localparam logic [2:0] OP_UNMAP  = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_STACK_START = 1'b0;
    localparam logic CFG_STACK_END   = 1'b1;

    // Request beat.
    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  dir_index;
        logic [9:0]  table_index;
        logic [31:0] page_address;
        logic [11:0] entry_flags;
    } t_req;

    // Response beat.
    typedef struct packed {
        logic [31:0] read_value;
        logic        found;
        logic [3:0]  found_dir;
        logic [9:0]  found_table;
        logic [31:0] freed_page;
        logic        freed_table_valid;
        logic [31:0] freed_table;
    } t_rsp;

    // Question put to the shared compare unit for one scanned entry.
    typedef struct packed {
        logic        find_mode;
        logic [31:0] entry;
        logic [9:0]  va_dir;
        logic [9:0]  va_tab;
        logic [9:0]  own_tab;
    } t_scan_req;

    typedef struct packed {
        logic hit;
    } t_scan_rsp;

endpackage

// ----- rtl/tpt_req_if.sv -----
// Request channel of the page table manager: valid, ready and one t_req.
// Depends on tpt_pkg.
`timescale 1ns / 1ps

interface tpt_req_if;
    import tpt_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tpt_rsp_if.sv -----
// Response channel of the page table manager: valid, ready and one t_rsp.
// Depends on tpt_pkg.
`timescale 1ns / 1ps

interface tpt_rsp_if;
    import tpt_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tpt_cfg_if.sv -----
// Configuration write channel: valid, ready, register index and data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

interface tpt_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tpt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tpt_scan_unit.sv -----
// Shared compare unit: judges one table entry during the free search or the
// unmap occupancy scan. Depends on tpt_pkg.
`timescale 1ns / 1ps

module tpt_scan_unit (
    input  tpt_pkg::t_scan_req i_req,
    input  logic [31:0]        i_stack_start,
    input  logic [31:0]        i_stack_end,
    output tpt_pkg::t_scan_rsp o_rsp
);
    import tpt_pkg::*;

    logic [31:0] va;
    logic        reserved;
    logic        present;

    // Virtual page address of the entry and the stack window check.
    assign va       = {i_req.va_dir, i_req.va_tab, 12'h000};
    assign reserved = (va >= i_stack_start) && (va <= i_stack_end);
    assign present  = i_req.entry[PRESENT_BIT];

    // Free search wants an absent, unreserved entry; the unmap scan wants
    // any other present entry of the same table.
    always_comb begin
        if (i_req.find_mode) begin
            o_rsp.hit = !present && !reserved;
        end else begin
            o_rsp.hit = present && (i_req.va_tab != i_req.own_tab);
        end
    end

endmodule

// ----- rtl/tpt_ctrl.sv -----
// Sequencer of the page table manager: directory registers, table memory
// port control, scan pipeline and response register.
// Depends on tpt_pkg, tpt_req_if and tpt_rsp_if.
`timescale 1ns / 1ps

module tpt_ctrl #(
    parameter int DIR_ENTRIES   = tpt_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tpt_pkg::TABLE_ENTRIES_DEF,
    parameter int DW            = $clog2(DIR_ENTRIES),
    parameter int TW            = $clog2(TABLE_ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tpt_req_if.sink            i_req,
    tpt_rsp_if.source          o_rsp,
    output logic               o_mem_we,
    output logic [DW+TW-1:0]   o_mem_waddr,
    output logic [31:0]        o_mem_wdata,
    output logic [DW+TW-1:0]   o_mem_raddr,
    input  logic [31:0]        i_mem_rdata,
    output tpt_pkg::t_scan_req o_scan_req,
    input  tpt_pkg::t_scan_rsp i_scan_rsp
);
    import tpt_pkg::*;

    localparam int AW        = DW + TW;
    localparam int MEM_DEPTH = DIR_ENTRIES * (1 << TW);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_EXEC  = 9'b000000100,
        S_FDIR  = 9'b000001000,
        S_FSCAN = 9'b000010000,
        S_USCAN = 9'b000100000,
        S_RD    = 9'b001000000,
        S_CAP   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Latched request.
    logic [2:0]  r_op;
    logic [3:0]  r_d;
    logic [9:0]  r_t;
    logic [31:0] r_word;

    // Scan counters and pipeline.
    logic [AW-1:0] r_clr, n_clr;
    logic [DW-1:0] r_si, n_si;
    logic [TW-1:0] r_sj, n_sj;
    logic [TW-1:0] r_pj, n_pj;
    logic          r_pv, n_pv;
    logic          r_iss_done, n_iss_done;
    logic          r_other, n_other;

    // Result being built and the response register.
    t_rsp r_res, n_res;
    t_rsp r_out;
    logic r_out_valid;

    // Directory.
    logic [31:0]   r_dir [DIR_ENTRIES];
    logic [DW-1:0] dir_addr;
    logic [31:0]   dir_rd;
    logic          dir_we;
    logic [31:0]   dir_wdata;

    logic          accept;
    logic          d_ok;
    logic          t_ok;
    logic [DW-1:0] d_addr;
    logic [TW-1:0] t_addr;
    logic [DW-1:0] scan_dir;
    logic          scan_last;
    logic          out_free;

    assign accept   = i_req.valid && i_req.ready;
    assign d_ok     = 32'(r_d) < 32'(DIR_ENTRIES);
    assign t_ok     = 32'(r_t) < 32'(TABLE_ENTRIES);
    assign d_addr   = DW'(r_d);
    assign t_addr   = TW'(r_t);
    assign out_free = !r_out_valid || o_rsp.ready;

    // Single directory read port, steered to the search slot in the directory step of a search.
    assign dir_addr = (r_state == S_FDIR) ? r_si : d_addr;
    assign dir_rd   = r_dir[dir_addr];

    assign scan_dir  = (r_state == S_FSCAN) ? r_si : d_addr;
    assign scan_last = r_pv && (r_pj == TW'(TABLE_ENTRIES - 1));

    // Question for the shared compare unit about the entry now returning.
    always_comb begin
        o_scan_req.find_mode = (r_state == S_FSCAN);
        o_scan_req.entry     = i_mem_rdata;
        o_scan_req.va_dir    = 10'(scan_dir);
        o_scan_req.va_tab    = 10'(r_pj);
        o_scan_req.own_tab   = r_t;
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_si        = r_si;
        n_sj        = r_sj;
        n_pj        = r_pj;
        n_pv        = 1'b0;
        n_iss_done  = r_iss_done;
        n_other     = r_other;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = {d_addr, t_addr};
        o_mem_wdata = r_word;
        o_mem_raddr = {d_addr, t_addr};
        dir_we      = 1'b0;
        dir_wdata   = r_word;

        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                o_mem_wdata = '0;
                n_clr       = r_clr + AW'(1);
                if (r_clr == AW'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res   = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_DONE;
                n_sj       = '0;
                n_iss_done = 1'b0;
                n_other    = 1'b0;
                case (r_op)
                    OP_WR_DIR: begin
                        dir_we = d_ok;
                    end
                    OP_WR_TAB: begin
                        o_mem_we = d_ok && t_ok;
                    end
                    OP_RD_DIR: begin
                        n_res.read_value = d_ok ? dir_rd : '0;
                    end
                    OP_RD_TAB: begin
                        if (d_ok && t_ok) begin
                            n_state = S_RD;
                        end
                    end
                    OP_FIND: begin
                        n_si    = '0;
                        n_state = S_FDIR;
                    end
                    OP_UNMAP: begin
                        if (d_ok && t_ok) begin
                            n_state = S_USCAN;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FDIR: begin
                // The last slot maps the directory itself and is never searched.
                n_sj       = '0;
                n_iss_done = 1'b0;
                if (r_si == DW'(DIR_ENTRIES - 1)) begin
                    n_state = S_DONE;
                end else if (dir_rd[PRESENT_BIT]) begin
                    n_state = S_FSCAN;
                end else begin
                    n_si = r_si + DW'(1);
                end
            end
            S_FSCAN, S_USCAN: begin
                // Issue one table read a cycle; judge each entry in the cycle after its read.
                o_mem_raddr = {scan_dir, r_sj};
                if (!r_iss_done) begin
                    n_pv = 1'b1;
                    n_pj = r_sj;
                    n_sj = r_sj + TW'(1);
                    if (r_sj == TW'(TABLE_ENTRIES - 1)) begin
                        n_iss_done = 1'b1;
                    end
                end
                if (r_state == S_FSCAN) begin
                    if (r_pv && i_scan_rsp.hit) begin
                        n_res.found       = 1'b1;
                        n_res.found_dir   = 4'(r_si);
                        n_res.found_table = 10'(r_pj);
                        n_state           = S_DONE;
                    end else if (scan_last) begin
                        n_si    = r_si + DW'(1);
                        n_state = S_FDIR;
                    end
                end else begin
                    if (r_pv && i_scan_rsp.hit) begin
                        n_other = 1'b1;
                        n_state = S_RD;
                    end else if (scan_last) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                n_state = S_DONE;
                if (r_op == OP_RD_TAB) begin
                    n_res.read_value = i_mem_rdata;
                end else begin
                    // Unmap: release the frame, clear the entry, and drop the
                    // table as well when nothing else in it is present.
                    n_res.freed_page = i_mem_rdata & FRAME_MASK;
                    o_mem_we         = 1'b1;
                    o_mem_wdata      = '0;
                    if (!r_other) begin
                        n_res.freed_table_valid = 1'b1;
                        n_res.freed_table       = dir_rd & FRAME_MASK;
                        dir_we                  = 1'b1;
                        dir_wdata               = '0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_pv       <= 1'b0;
            r_iss_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_pv       <= n_pv;
            r_iss_done <= n_iss_done;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_si    <= n_si;
        r_sj    <= n_sj;
        r_pj    <= n_pj;
        r_other <= n_other;
        r_res   <= n_res;
        if (accept) begin
            r_op   <= i_req.data.op;
            r_d    <= i_req.data.dir_index;
            r_t    <= i_req.data.table_index;
            r_word <= i_req.data.page_address | {20'h00000, i_req.data.entry_flags};
        end
    end

    // Directory entries, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIR_ENTRIES; k++) begin
                r_dir[k] <= '0;
            end
        end else if (dir_we) begin
            r_dir[d_addr] <= dir_wdata;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

// ----- rtl/two_level_page_table_manager.sv -----
// Top level of the two-level page table manager: configuration registers,
// table memory, shared compare unit and sequencer.
// Depends on tpt_pkg, the three channel interfaces, tpt_ram, tpt_scan_unit, tpt_ctrl.
//
//   Channel  Dir  Beat                         Handshake
//   i_req    in   op, slot, entry, word, flags valid / ready
//   o_rsp    out  one result per request       valid / ready
//   i_cfg    in   register index and data      valid / ready (always ready)
//
// After reset a clearing pass writes every table entry to zero, one a cycle,
// before the first request is taken. Find and unmap scan the table entries
// through the single table memory read port, one entry per cycle. One request
// is worked on at a time; a held response stalls completion only.
`timescale 1ns / 1ps

module two_level_page_table_manager #(
    parameter int DIR_ENTRIES   = tpt_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tpt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpt_req_if.sink    i_req,
    tpt_rsp_if.source  o_rsp,
    tpt_cfg_if.sink    i_cfg
);
    import tpt_pkg::*;

    localparam int DW        = $clog2(DIR_ENTRIES);
    localparam int TW        = $clog2(TABLE_ENTRIES);
    localparam int MEM_DEPTH = DIR_ENTRIES * (1 << TW);

    logic [31:0]      r_stack_start;
    logic [31:0]      r_stack_end;
    logic             mem_we;
    logic [DW+TW-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [DW+TW-1:0] mem_raddr;
    logic [31:0]      mem_rdata;
    t_scan_req        scan_req;
    t_scan_rsp        scan_rsp;

    // Stack window registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_start <= 32'hFFFF_FFFF;
            r_stack_end   <= 32'h0000_0000;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STACK_START: r_stack_start <= i_cfg.data;
                CFG_STACK_END:   r_stack_end   <= i_cfg.data;
                default:         r_stack_end   <= r_stack_end;
            endcase
        end
    end

    // Page table memory, one table per directory slot.
    tpt_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Entry compare unit shared by both scans.
    tpt_scan_unit u_scan (
        .i_req         (scan_req),
        .i_stack_start (r_stack_start),
        .i_stack_end   (r_stack_end),
        .o_rsp         (scan_rsp)
    );

    // Operation sequencer.
    tpt_ctrl #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DW            (DW),
        .TW            (TW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_scan_req  (scan_req),
        .i_scan_rsp  (scan_rsp)
    );

endmodule
